@@ rtl/two_level_tlb_zero_block_map_macros.svh @@
// assertion macros shared by the checker
`ifndef TWO_LEVEL_TLB_ZERO_BLOCK_MAP_MACROS_SVH
`define TWO_LEVEL_TLB_ZERO_BLOCK_MAP_MACROS_SVH
// same-cycle implication
`define TLBZ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlbz check failed");
// next-cycle implication
`define TLBZ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlbz check failed");
`endif

@@ rtl/tlbz_pkg.sv @@
// package: shared types and constants of the zero-block tlb
package tlbz_pkg;
  localparam int ADDR_W  = 32;
  localparam int SHIFT_W = 5;
  localparam int BLOCK_W = 5;
  localparam int BYTES_W = 5;
  localparam int CFG_IDX_W = 2;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_SHIFT  = 2'd0,
    CFG_BLOCK_SHIFT = 2'd1,
    CFG_MAP_ENABLED = 2'd2
  } cfg_idx_t;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST  = 5'd12;
  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 5'd7;

  localparam logic [BYTES_W-1:0] BYTES_BASE  = 5'd8;
  localparam logic [BYTES_W-1:0] BYTES_FILL  = 5'd12;
  localparam logic [BYTES_W-1:0] BYTES_DIRTY = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAG,
    ST_MAP,
    ST_DONE
  } state_t;
endpackage

@@ rtl/tlbz_ifs.sv @@
// handshake interfaces for the access and result channels
interface tlbz_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] address;
  logic        new_bit;
  modport source (output valid, command, address, new_bit, input ready);
  modport sink   (input valid, command, address, new_bit, output ready);
endinterface

interface tlbz_out_if;
  logic       valid;
  logic       ready;
  logic       block_bit;
  logic       first_level_hit;
  logic       second_level_used;
  logic       second_level_hit;
  logic [4:0] bytes_charged;
  logic       out_of_range;
  modport source (output valid, block_bit, first_level_hit, second_level_used,
                  second_level_hit, bytes_charged, out_of_range, input ready);
  modport sink   (input valid, block_bit, first_level_hit, second_level_used,
                  second_level_hit, bytes_charged, out_of_range, output ready);
endinterface

@@ rtl/tlbz_ram.sv @@
// generic single-port ram with registered read
module tlbz_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/tlbz_ways.sv @@
// fully associative tag array with lru order; combinational search, fill on update
module tlbz_ways #(
  parameter int WAYS  = 16,
  parameter int TAG_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TAG_W-1:0] tag,
  input  logic             upd_en,
  output logic             hit
);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [TAG_W-1:0] tag_r [WAYS];
  logic [WAYS-1:0]  valid_r;
  logic [WW-1:0]    order_r [WAYS];
  logic [WW-1:0]    hit_way;
  logic [WW-1:0]    way;
  logic [WAYS-1:0]  shift_en;
  logic             seen;

  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    // last match wins: highest way
    for (int i = 0; i < WAYS; i++) begin
      if (valid_r[i] && tag_r[i] == tag) begin
        hit = 1'b1;
        hit_way = WW'(i);
      end
    end
    way = hit ? hit_way : order_r[0];
    seen = 1'b0;
    for (int p = 0; p < WAYS; p++) begin
      seen = seen | (order_r[p] == way);
      shift_en[p] = seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < WAYS; i++) begin
        order_r[i] <= WW'(i);
      end
    end else if (upd_en) begin
      if (!hit) begin
        valid_r[way] <= 1'b1;
      end
      if (WAYS > 1) begin
        for (int p = 0; p < WAYS - 1; p++) begin
          if (shift_en[p]) begin
            order_r[p] <= order_r[p+1];
          end
        end
        order_r[WAYS-1] <= way;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && !hit) begin
      tag_r[way] <= tag;
    end
  end
endmodule

@@ rtl/two_level_tlb_zero_block_map.sv @@
// top level: two-level zero-block tlb over a page map memory
//
// Accesses arrive on in_if (command, address, new_bit) and one result per
// access leaves on out_if; both use valid/ready, an item moves when both are
// high. Configuration registers are written through cfg_we/cfg_index/
// cfg_wdata; the user must write them only while no access is in flight,
// which the block does not enforce; unknown indexes are dropped. One
// access is handled at a time: accept, tag search of both levels and lru
// update of the levels used, map memory read, then block bit read (lookup)
// or read-modify-write (update); a page beyond the map skips the map. The
// result register is loaded in the done state once it is free, and
// in_if.ready rises the cycle after it is loaded. After reset the map
// memory is cleared one page per cycle, all MAP_PAGES pages (4096 by
// default), and in_if.ready stays low meanwhile; tag arrays start invalid
// at once. If the receiver stalls, the result is held in the output
// register and the block waits with the next result.
module two_level_tlb_zero_block_map
  import tlbz_pkg::*;
#(
  parameter int FIRST_WAYS = 16,
  parameter int MAP_PAGES  = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tlbz_in_if.sink              in_if,
  tlbz_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SHIFT_W-1:0]   cfg_wdata
);
  localparam int SECOND_WAYS = FIRST_WAYS * 4;
  localparam int TAG_W = $clog2(MAP_PAGES);
  localparam int MAP_W = 33;

  state_t state_r, state_nxt;

  logic [SHIFT_W-1:0] page_shift_r, block_shift_r;
  logic               map_enabled_r;

  logic               cmd_r;
  logic [ADDR_W-1:0]  addr_r;
  logic               nbit_r;
  logic [TAG_W-1:0]   page_r;
  logic [BLOCK_W-1:0] block_r;
  logic oor_r, l1hit_r, l2used_r, l2hit_r;
  logic               res_bit_r;
  logic [BYTES_W-1:0] res_bytes_r;
  logic [TAG_W-1:0]   clr_idx_r;

  logic               out_valid_r;
  logic               o_bit_r, o_l1hit_r, o_l2used_r, o_l2hit_r, o_oor_r;
  logic [BYTES_W-1:0] o_bytes_r;

  logic [ADDR_W-1:0]  page_full, blk_full;
  logic               oor;
  logic [SHIFT_W-1:0] diff;
  logic [2:0]         diff_c;
  logic [5:0]         mask6;
  logic [BLOCK_W-1:0] block;
  logic               l1_upd, l2_upd, l1_hit, l2_hit;
  logic               ram_we;
  logic [TAG_W-1:0]   ram_addr;
  logic [MAP_W-1:0]   ram_wdata, ram_rdata;
  logic [31:0]        new_bits;
  logic               bit_nxt;
  logic [BYTES_W-1:0] bytes_nxt;
  logic               load_out;

  tlbz_ways #(.WAYS(FIRST_WAYS), .TAG_W(TAG_W)) u_first (
    .clk(clk), .rst_n(rst_n), .tag(page_full[TAG_W-1:0]), .upd_en(l1_upd), .hit(l1_hit)
  );

  tlbz_ways #(.WAYS(SECOND_WAYS), .TAG_W(TAG_W)) u_second (
    .clk(clk), .rst_n(rst_n), .tag(page_full[TAG_W-1:0]), .upd_en(l2_upd), .hit(l2_hit)
  );

  tlbz_ram #(.WIDTH(MAP_W), .DEPTH(MAP_PAGES)) u_map (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // address split
  always_comb begin
    page_full = addr_r >> page_shift_r;
    oor = page_full >= ADDR_W'(MAP_PAGES);
    diff = (page_shift_r > block_shift_r) ? page_shift_r - block_shift_r : '0;
    diff_c = (diff > 5'd5) ? 3'd5 : diff[2:0];
    mask6 = (6'd1 << diff_c) - 6'd1;
    blk_full = addr_r >> block_shift_r;
    block = blk_full[BLOCK_W-1:0] & mask6[BLOCK_W-1:0];
  end

  assign l1_upd = (state_r == ST_TAG) && !oor && (cmd_r == CMD_LOOKUP);
  assign l2_upd = (state_r == ST_TAG) && !oor && ((cmd_r == CMD_UPDATE) || !l1_hit);

  // block bit update and charge, map word is {dirty, bits}
  always_comb begin
    new_bits = ram_rdata[31:0];
    new_bits[block_r] = nbit_r;
    bit_nxt = 1'b0;
    bytes_nxt = '0;
    if (cmd_r == CMD_LOOKUP) begin
      bit_nxt = map_enabled_r ? ram_rdata[block_r] : 1'b1;
      if (l2used_r && !l2hit_r) begin
        bytes_nxt = map_enabled_r ? BYTES_FILL : BYTES_BASE;
      end
    end else if (!l2hit_r) begin
      if (ram_rdata[32]) begin
        bytes_nxt = map_enabled_r ? BYTES_DIRTY : BYTES_BASE;
      end else begin
        bytes_nxt = map_enabled_r ? BYTES_FILL : BYTES_BASE;
      end
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = page_full[TAG_W-1:0];
    ram_wdata = {1'b1, new_bits};
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_idx_r;
        ram_wdata = '0;
      end
      ST_MAP: begin
        ram_we = (cmd_r == CMD_UPDATE);
        ram_addr = page_r;
      end
      default: begin
      end
    endcase
  end

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_idx_r == TAG_W'(MAP_PAGES - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_if.valid) state_nxt = ST_TAG;
      ST_TAG:   state_nxt = oor ? ST_DONE : ST_MAP;
      ST_MAP:   state_nxt = ST_DONE;
      ST_DONE:  if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  assign in_if.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_idx_r <= '0;
      out_valid_r <= 1'b0;
      page_shift_r <= PAGE_SHIFT_RST;
      block_shift_r <= BLOCK_SHIFT_RST;
      map_enabled_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      out_valid_r <= load_out || (out_valid_r && !out_if.ready);
      if (cfg_we) begin
        priority case (cfg_index)
          CFG_PAGE_SHIFT:  page_shift_r <= cfg_wdata;
          CFG_BLOCK_SHIFT: block_shift_r <= cfg_wdata;
          CFG_MAP_ENABLED: map_enabled_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      cmd_r <= in_if.command;
      addr_r <= in_if.address;
      nbit_r <= in_if.new_bit;
    end
    if (state_r == ST_TAG) begin
      page_r <= page_full[TAG_W-1:0];
      block_r <= block;
      oor_r <= oor;
      l1hit_r <= !oor && (cmd_r == CMD_LOOKUP) && l1_hit;
      l2used_r <= l2_upd;
      l2hit_r <= l2_upd && l2_hit;
      res_bit_r <= 1'b0;
      res_bytes_r <= '0;
    end
    if (state_r == ST_MAP) begin
      res_bit_r <= bit_nxt;
      res_bytes_r <= bytes_nxt;
    end
    if (load_out) begin
      o_bit_r <= res_bit_r;
      o_l1hit_r <= l1hit_r;
      o_l2used_r <= l2used_r;
      o_l2hit_r <= l2hit_r;
      o_bytes_r <= res_bytes_r;
      o_oor_r <= oor_r;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.block_bit = o_bit_r;
  assign out_if.first_level_hit = o_l1hit_r;
  assign out_if.second_level_used = o_l2used_r;
  assign out_if.second_level_hit = o_l2hit_r;
  assign out_if.bytes_charged = o_bytes_r;
  assign out_if.out_of_range = o_oor_r;
endmodule

@@ rtl/tlbz_checker.sv @@
// port-level checker for the zero-block tlb, bound to the top level
`include "two_level_tlb_zero_block_map_macros.svh"
module tlbz_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       block_bit,
  input logic       first_level_hit,
  input logic       second_level_used,
  input logic       second_level_hit,
  input logic [4:0] bytes_charged,
  input logic       out_of_range
);
  logic [9:0] payload;
  assign payload = {block_bit, first_level_hit, second_level_used, second_level_hit,
                    bytes_charged, out_of_range};

  // stalled result holds
  `TLBZ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(payload))
  // one item in flight at a time
  `TLBZ_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)
  // ignored page reports nothing else
  `TLBZ_ASSERT_IMP(a_oor_clean, out_valid && out_of_range,
                   !block_bit && !first_level_hit && !second_level_used &&
                   !second_level_hit && bytes_charged == 5'd0)
  // first-level hit never reaches the second level
  `TLBZ_ASSERT_IMP(a_l1_hit, out_valid && first_level_hit, !second_level_used)
  // a charge only comes from a second-level miss
  `TLBZ_ASSERT_IMP(a_charge, out_valid && bytes_charged != 5'd0,
                   second_level_used && !second_level_hit &&
                   (bytes_charged == 5'd8 || bytes_charged == 5'd12 ||
                    bytes_charged == 5'd16))
endmodule

bind two_level_tlb_zero_block_map tlbz_checker u_tlbz_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_if.valid),
  .in_ready(in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .block_bit(out_if.block_bit),
  .first_level_hit(out_if.first_level_hit),
  .second_level_used(out_if.second_level_used),
  .second_level_hit(out_if.second_level_hit),
  .bytes_charged(out_if.bytes_charged),
  .out_of_range(out_if.out_of_range)
);
